[sv/whp_pkg.sv]
// ----------------------------------------------------------------------------
// whp_pkg
// Types and constants shared by the WAV header parser.
// ----------------------------------------------------------------------------
`default_nettype none

package whp_pkg;

    localparam logic [31:0] ID_RIFF = 32'h5249_4646;
    localparam logic [31:0] ID_WAVE = 32'h5741_5645;
    localparam logic [31:0] ID_FMT  = 32'h666D_7420;
    localparam logic [31:0] ID_DATA = 32'h6461_7461;

    localparam logic [31:0] FMT_BODY_BYTES = 32'd16;

    localparam logic [31:0] RIFF_LAST_IDX   = 32'd11;
    localparam logic [31:0] RIFF_MAGIC_IDX  = 32'd3;
    localparam logic [31:0] HDR_ID_BYTES    = 32'd4;
    localparam logic [31:0] HDR_LAST_IDX    = 32'd7;
    localparam logic [31:0] FMT_CH_LO_IDX   = 32'd2;
    localparam logic [31:0] FMT_CH_HI_IDX   = 32'd3;
    localparam logic [31:0] FMT_RATE_B0_IDX = 32'd4;
    localparam logic [31:0] FMT_RATE_B1_IDX = 32'd5;
    localparam logic [31:0] FMT_RATE_B2_IDX = 32'd6;
    localparam logic [31:0] FMT_RATE_B3_IDX = 32'd7;
    localparam logic [31:0] FMT_BITS_LO_IDX = 32'd14;
    localparam logic [31:0] FMT_BITS_HI_IDX = 32'd15;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_MAGIC = 2'd1,
        ST_TRUNCATED = 2'd2
    } status_t;

    typedef enum logic [4:0] {
        PH_RIFF = 5'b00001,
        PH_HDR  = 5'b00010,
        PH_FMT  = 5'b00100,
        PH_SKIP = 5'b01000,
        PH_DONE = 5'b10000
    } phase_t;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       first_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        fmt_seen;
        logic [15:0] channels;
        logic [31:0] samp_rate;
        logic [15:0] samp_bits;
        logic [31:0] pcm_offset;
        logic [31:0] pcm_size;
    } out_item_t;

endpackage

`default_nettype wire

[sv/wav_header_parser_top.sv]
// ----------------------------------------------------------------------------
// wav_header_parser_top
// Byte-wide RIFF/WAVE header parser with a registered result.
// ----------------------------------------------------------------------------
// The block takes one file byte per cycle and gives one result per file: the
// format fields, the offset and size of the data chunk, or an error status
// (bad magic, stream ended before the data chunk). Each byte is parsed in the
// cycle it is accepted, so the rate is one byte per clock; the only limit is
// the single result register, which holds input back only while a result
// waits unread on the m_ side. Mark the first byte of each file with
// first_byte; after a result, bytes are dropped until the next such mark.
`default_nettype none

module wav_header_parser_top (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire whp_pkg::in_item_t  s_item,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output whp_pkg::out_item_t      m_item
);

    whp_pkg::phase_t    phase_reg, phase_next;
    logic [31:0]        cnt_reg, cnt_next;
    logic [31:0]        id_reg, id_next;
    logic [31:0]        size_reg, size_next;
    logic [31:0]        pos_reg, pos_next;
    logic [15:0]        chan_reg, chan_next;
    logic [31:0]        rate_reg, rate_next;
    logic [15:0]        bits_reg, bits_next;
    logic               fmt_seen_reg, fmt_seen_next;
    logic               m_valid_reg, m_valid_next;
    whp_pkg::out_item_t m_item_reg, m_item_next;

    whp_pkg::phase_t    cur_phase;
    logic [31:0]        cur_cnt, cur_id, cur_size, cur_pos, cur_rate;
    logic [15:0]        cur_chan, cur_bits;
    logic               cur_fmt_seen;
    logic               s_accept;
    logic               emit;
    whp_pkg::out_item_t res;
    logic [7:0]         b;

    assign s_accept = s_valid && s_ready;
    assign s_ready  = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_item   = m_item_reg;
    assign b        = s_item.byte_value;

    always_comb begin
        cur_phase    = s_item.first_byte ? whp_pkg::PH_RIFF : phase_reg;
        cur_cnt      = s_item.first_byte ? 32'd0 : cnt_reg;
        cur_id       = s_item.first_byte ? 32'd0 : id_reg;
        cur_size     = s_item.first_byte ? 32'd0 : size_reg;
        cur_pos      = s_item.first_byte ? 32'd0 : pos_reg;
        cur_chan     = s_item.first_byte ? 16'd0 : chan_reg;
        cur_rate     = s_item.first_byte ? 32'd0 : rate_reg;
        cur_bits     = s_item.first_byte ? 16'd0 : bits_reg;
        cur_fmt_seen = s_item.first_byte ? 1'b0  : fmt_seen_reg;

        phase_next    = cur_phase;
        cnt_next      = cur_cnt;
        id_next       = cur_id;
        size_next     = cur_size;
        pos_next      = cur_pos;
        chan_next     = cur_chan;
        rate_next     = cur_rate;
        bits_next     = cur_bits;
        fmt_seen_next = cur_fmt_seen;
        emit          = 1'b0;
        res           = '0;

        if (cur_phase != whp_pkg::PH_DONE) begin
            if (cur_pos != 32'hFFFF_FFFF) begin
                pos_next = cur_pos + 32'd1;
            end
            unique case (cur_phase)
                whp_pkg::PH_RIFF: begin
                    id_next  = {cur_id[23:0], b};
                    cnt_next = cur_cnt + 32'd1;
                    if (cur_cnt == whp_pkg::RIFF_MAGIC_IDX && id_next != whp_pkg::ID_RIFF) begin
                        size_next = 32'd1;
                    end
                    if (cur_cnt == whp_pkg::RIFF_LAST_IDX) begin
                        if (size_next != 32'd0 || id_next != whp_pkg::ID_WAVE) begin
                            emit       = 1'b1;
                            res.status = whp_pkg::ST_BAD_MAGIC;
                            phase_next = whp_pkg::PH_DONE;
                        end else begin
                            phase_next = whp_pkg::PH_HDR;
                            cnt_next   = 32'd0;
                            size_next  = 32'd0;
                        end
                    end
                end
                whp_pkg::PH_HDR: begin
                    if (cur_cnt < whp_pkg::HDR_ID_BYTES) begin
                        id_next = {cur_id[23:0], b};
                    end else begin
                        size_next = {b, cur_size[31:8]};
                    end
                    cnt_next = cur_cnt + 32'd1;
                    if (cur_cnt == whp_pkg::HDR_LAST_IDX) begin
                        cnt_next = 32'd0;
                        if (id_next == whp_pkg::ID_FMT) begin
                            phase_next = whp_pkg::PH_FMT;
                        end else if (id_next == whp_pkg::ID_DATA) begin
                            emit           = 1'b1;
                            res.status     = whp_pkg::ST_OK;
                            res.fmt_seen   = cur_fmt_seen;
                            res.channels   = cur_chan;
                            res.samp_rate  = cur_rate;
                            res.samp_bits  = cur_bits;
                            res.pcm_offset = pos_next;
                            res.pcm_size   = size_next;
                            phase_next     = whp_pkg::PH_DONE;
                        end else if (size_next != 32'd0) begin
                            phase_next = whp_pkg::PH_SKIP;
                            cnt_next   = size_next;
                        end
                    end
                end
                whp_pkg::PH_FMT: begin
                    if (cur_cnt == whp_pkg::FMT_CH_LO_IDX)   chan_next[7:0]   = b;
                    if (cur_cnt == whp_pkg::FMT_CH_HI_IDX)   chan_next[15:8]  = b;
                    if (cur_cnt == whp_pkg::FMT_RATE_B0_IDX) rate_next[7:0]   = b;
                    if (cur_cnt == whp_pkg::FMT_RATE_B1_IDX) rate_next[15:8]  = b;
                    if (cur_cnt == whp_pkg::FMT_RATE_B2_IDX) rate_next[23:16] = b;
                    if (cur_cnt == whp_pkg::FMT_RATE_B3_IDX) rate_next[31:24] = b;
                    if (cur_cnt == whp_pkg::FMT_BITS_LO_IDX) bits_next[7:0]   = b;
                    if (cur_cnt == whp_pkg::FMT_BITS_HI_IDX) bits_next[15:8]  = b;
                    cnt_next = cur_cnt + 32'd1;
                    if (cur_cnt == whp_pkg::FMT_BITS_HI_IDX) begin
                        fmt_seen_next = 1'b1;
                        if (cur_size > whp_pkg::FMT_BODY_BYTES) begin
                            phase_next = whp_pkg::PH_SKIP;
                            cnt_next   = cur_size - whp_pkg::FMT_BODY_BYTES;
                        end else begin
                            phase_next = whp_pkg::PH_HDR;
                            cnt_next   = 32'd0;
                        end
                    end
                end
                whp_pkg::PH_SKIP: begin
                    cnt_next = cur_cnt - 32'd1;
                    if (cnt_next == 32'd0) begin
                        phase_next = whp_pkg::PH_HDR;
                    end
                end
                default: begin
                    phase_next = whp_pkg::PH_DONE;
                end
            endcase
            if (s_item.last_byte && !emit) begin
                emit       = 1'b1;
                res        = '0;
                res.status = whp_pkg::ST_TRUNCATED;
                phase_next = whp_pkg::PH_DONE;
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        m_item_next  = m_item_reg;
        if (s_accept && emit) begin
            m_valid_next = 1'b1;
            m_item_next  = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= whp_pkg::PH_RIFF;
            cnt_reg      <= '0;
            id_reg       <= '0;
            size_reg     <= '0;
            pos_reg      <= '0;
            chan_reg     <= '0;
            rate_reg     <= '0;
            bits_reg     <= '0;
            fmt_seen_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (s_accept) begin
                phase_reg    <= phase_next;
                cnt_reg      <= cnt_next;
                id_reg       <= id_next;
                size_reg     <= size_next;
                pos_reg      <= pos_next;
                chan_reg     <= chan_next;
                rate_reg     <= rate_next;
                bits_reg     <= bits_next;
                fmt_seen_reg <= fmt_seen_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        m_item_reg <= m_item_next;
    end

    a_emit_ends_file: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && emit |=> phase_reg == whp_pkg::PH_DONE)
        else $error("phase not done after result");

    a_error_fields_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_item_reg.status != whp_pkg::ST_OK
            |-> m_item_reg.pcm_offset == 32'd0 && m_item_reg.pcm_size == 32'd0
                && m_item_reg.fmt_seen == 1'b0)
        else $error("error result carries fields");

    a_skip_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == whp_pkg::PH_SKIP |-> cnt_reg != 32'd0)
        else $error("skip phase with zero count");

    a_pos_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && !s_item.first_byte |=> pos_reg >= $past(pos_reg))
        else $error("byte position went back");

endmodule

`default_nettype wire

[test/wav_header_parser_checker.sv]
// ----------------------------------------------------------------------------
// wav_header_parser_checker
// Watches both channels of the WAV header parser and checks every result.
// ----------------------------------------------------------------------------
// Each accepted byte is run through a local copy of the parser state. The
// header summary or error status that it predicts is queued, and each result
// taken from the m_ side is compared with the oldest queued one, field by
// field. Failures are counted and handed to the testbench top.
`default_nettype none

module wav_header_parser_checker (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    input  wire logic               s_ready,
    input  wire whp_pkg::in_item_t  s_item,
    input  wire logic               m_valid,
    input  wire logic               m_ready,
    input  wire whp_pkg::out_item_t m_item,
    output int                      fail_count,
    output int                      pending
);

    timeunit 1ns;
    timeprecision 1ps;

    whp_pkg::phase_t phase;
    logic [31:0]     sec_cnt;
    logic [31:0]     id_acc;
    logic [31:0]     size_acc;
    logic [31:0]     byte_pos;
    logic [15:0]     ch_held;
    logic [31:0]     rate_held;
    logic [15:0]     bits_held;
    logic            fmt_held;

    whp_pkg::out_item_t expected_headers[$];

    initial begin
        fail_count = 0;
        pending    = 0;
    end

    function automatic void clear_parser();
        phase     = whp_pkg::PH_RIFF;
        sec_cnt   = '0;
        id_acc    = '0;
        size_acc  = '0;
        byte_pos  = '0;
        ch_held   = '0;
        rate_held = '0;
        bits_held = '0;
        fmt_held  = 1'b0;
    endfunction

    function automatic bit parse_byte(input whp_pkg::in_item_t it,
                                      output whp_pkg::out_item_t hdr);
        logic [31:0] k;
        logic [7:0]  b;
        hdr = '0;
        b   = it.byte_value;
        if (it.first_byte) begin
            clear_parser();
        end
        if (phase == whp_pkg::PH_DONE) begin
            return 1'b0;
        end
        if (byte_pos != 32'hFFFF_FFFF) begin
            byte_pos = byte_pos + 32'd1;
        end
        k = sec_cnt;
        case (phase)
            whp_pkg::PH_RIFF: begin
                id_acc = {id_acc[23:0], b};
                if (k == whp_pkg::RIFF_MAGIC_IDX && id_acc != whp_pkg::ID_RIFF) begin
                    size_acc = 32'd1;
                end
                sec_cnt = k + 32'd1;
                if (k == whp_pkg::RIFF_LAST_IDX) begin
                    if (size_acc != 0 || id_acc != whp_pkg::ID_WAVE) begin
                        hdr.status = whp_pkg::ST_BAD_MAGIC;
                        phase      = whp_pkg::PH_DONE;
                        return 1'b1;
                    end
                    phase    = whp_pkg::PH_HDR;
                    sec_cnt  = '0;
                    size_acc = '0;
                end
            end
            whp_pkg::PH_HDR: begin
                if (k < whp_pkg::HDR_ID_BYTES) begin
                    id_acc = {id_acc[23:0], b};
                end else begin
                    size_acc = {b, size_acc[31:8]};
                end
                sec_cnt = k + 32'd1;
                if (k == whp_pkg::HDR_LAST_IDX) begin
                    sec_cnt = '0;
                    if (id_acc == whp_pkg::ID_FMT) begin
                        phase = whp_pkg::PH_FMT;
                    end else if (id_acc == whp_pkg::ID_DATA) begin
                        hdr.status     = whp_pkg::ST_OK;
                        hdr.fmt_seen   = fmt_held;
                        hdr.channels   = ch_held;
                        hdr.samp_rate  = rate_held;
                        hdr.samp_bits  = bits_held;
                        hdr.pcm_offset = byte_pos;
                        hdr.pcm_size   = size_acc;
                        phase          = whp_pkg::PH_DONE;
                        return 1'b1;
                    end else if (size_acc != 0) begin
                        phase   = whp_pkg::PH_SKIP;
                        sec_cnt = size_acc;
                    end
                end
            end
            whp_pkg::PH_FMT: begin
                case (k)
                    whp_pkg::FMT_CH_LO_IDX:   ch_held[7:0]     = b;
                    whp_pkg::FMT_CH_HI_IDX:   ch_held[15:8]    = b;
                    whp_pkg::FMT_RATE_B0_IDX: rate_held[7:0]   = b;
                    whp_pkg::FMT_RATE_B1_IDX: rate_held[15:8]  = b;
                    whp_pkg::FMT_RATE_B2_IDX: rate_held[23:16] = b;
                    whp_pkg::FMT_RATE_B3_IDX: rate_held[31:24] = b;
                    whp_pkg::FMT_BITS_LO_IDX: bits_held[7:0]   = b;
                    whp_pkg::FMT_BITS_HI_IDX: bits_held[15:8]  = b;
                    default: ;
                endcase
                sec_cnt = k + 32'd1;
                if (k == whp_pkg::FMT_BITS_HI_IDX) begin
                    fmt_held = 1'b1;
                    if (size_acc > whp_pkg::FMT_BODY_BYTES) begin
                        phase   = whp_pkg::PH_SKIP;
                        sec_cnt = size_acc - whp_pkg::FMT_BODY_BYTES;
                    end else begin
                        phase   = whp_pkg::PH_HDR;
                        sec_cnt = '0;
                    end
                end
            end
            default: begin
                sec_cnt = k - 32'd1;
                if (sec_cnt == 0) begin
                    phase = whp_pkg::PH_HDR;
                end
            end
        endcase
        if (it.last_byte) begin
            hdr.status = whp_pkg::ST_TRUNCATED;
            phase      = whp_pkg::PH_DONE;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic int field_differs(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge aclk) begin : track
        whp_pkg::out_item_t hdr;
        if (!aresetn) begin
            clear_parser();
            expected_headers.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_headers.size() == 0) begin
                    $error("result with none expected: status %0d", m_item.status);
                    fail_count++;
                end else begin
                    hdr = expected_headers.pop_front();
                    fail_count += field_differs("status", 32'(hdr.status),
                                                32'(m_item.status));
                    fail_count += field_differs("fmt_seen", 32'(hdr.fmt_seen),
                                                32'(m_item.fmt_seen));
                    fail_count += field_differs("channels", 32'(hdr.channels),
                                                32'(m_item.channels));
                    fail_count += field_differs("samp_rate", hdr.samp_rate,
                                                m_item.samp_rate);
                    fail_count += field_differs("samp_bits", 32'(hdr.samp_bits),
                                                32'(m_item.samp_bits));
                    fail_count += field_differs("pcm_offset", hdr.pcm_offset,
                                                m_item.pcm_offset);
                    fail_count += field_differs("pcm_size", hdr.pcm_size, m_item.pcm_size);
                end
            end
            if (s_valid && s_ready) begin
                if (parse_byte(s_item, hdr)) begin
                    expected_headers.push_back(hdr);
                end
            end
        end
        pending = expected_headers.size();
    end

endmodule

`default_nettype wire

[test/wav_header_parser_top_tb.sv]
// ----------------------------------------------------------------------------
// wav_header_parser_top_tb
// Byte-stream stimulus and verdict for the WAV header parser.
// ----------------------------------------------------------------------------
// Feeds a few hand-built files (all-ones sizes, bad magic, early end, short
// and long fmt chunks, restarts) and then random files, mostly well formed,
// some with broken magic, an early last byte or a cut-off tail. Both sides
// idle at random; the checker module predicts and compares the results.
`default_nettype none

module wav_header_parser_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [31:0] ID_LIST  = 32'h4C49_5354;
    localparam logic [31:0] ID_JUNK  = 32'h6A75_6E6B;
    localparam logic [31:0] BAD_RIFF = 32'h5249_4658;
    localparam logic [31:0] BAD_WAVE = 32'h5741_5658;
    localparam int          STALL_LIMIT = 2000;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    whp_pkg::in_item_t  s_item;
    logic               m_valid;
    logic               m_ready;
    whp_pkg::out_item_t m_item;
    int                 fail_count;
    int                 pending;

    bit                 steady;
    int                 bytes_sent;
    int                 files_sent;
    whp_pkg::in_item_t  file_q[$];

    wav_header_parser_top dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    wav_header_parser_checker u_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_item     (m_item),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic void add_byte(logic [7:0] b);
        whp_pkg::in_item_t it;
        it            = '0;
        it.byte_value = b;
        file_q.push_back(it);
    endfunction

    function automatic void add_id(logic [31:0] id);
        for (int i = 3; i >= 0; i--) begin
            add_byte(id[8*i +: 8]);
        end
    endfunction

    function automatic void add_le32(logic [31:0] v);
        for (int i = 0; i < 4; i++) begin
            add_byte(v[8*i +: 8]);
        end
    endfunction

    function automatic void add_le16(logic [15:0] v);
        add_byte(v[7:0]);
        add_byte(v[15:8]);
    endfunction

    function automatic void add_noise(int n);
        repeat (n) add_byte(8'($urandom_range(0, 255)));
    endfunction

    function automatic void add_header(logic [31:0] riff, logic [31:0] size, logic [31:0] wave);
        add_id(riff);
        add_le32(size);
        add_id(wave);
    endfunction

    function automatic void add_fmt(logic [31:0] size, logic [15:0] ch, logic [31:0] rate,
                                    logic [15:0] bits);
        add_id(whp_pkg::ID_FMT);
        add_le32(size);
        add_le16(16'($urandom));
        add_le16(ch);
        add_le32(rate);
        add_le32($urandom);
        add_le16(16'($urandom));
        add_le16(bits);
        if (size > whp_pkg::FMT_BODY_BYTES) begin
            add_noise(int'(size - whp_pkg::FMT_BODY_BYTES));
        end
    endfunction

    function automatic void add_chunk(logic [31:0] id, int size);
        add_id(id);
        add_le32(size);
        add_noise(size);
    endfunction

    function automatic void add_data(logic [31:0] size);
        add_id(whp_pkg::ID_DATA);
        add_le32(size);
    endfunction

    function automatic void mark_last(int idx);
        file_q[idx].last_byte = 1'b1;
    endfunction

    task automatic send_byte(input whp_pkg::in_item_t it);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 11);
        repeat (gap) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_item  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        bytes_sent++;
    endtask

    task automatic send_file(input bit mark_first);
        file_q[0].first_byte = mark_first;
        foreach (file_q[i]) begin
            send_byte(file_q[i]);
        end
        file_q.delete();
        files_sent++;
    endtask

    task automatic hold_off();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
    endtask

    task automatic build_random_file();
        int          n;
        int          pick;
        int          ending;
        int          idx;
        logic [31:0] sz;
        add_header(whp_pkg::ID_RIFF, $urandom, whp_pkg::ID_WAVE);
        if ($urandom_range(0, 9) == 0) begin
            pick = $urandom_range(0, 7);
            if (pick >= 4) begin
                pick += 4;
            end
            file_q[pick].byte_value = file_q[pick].byte_value ^ (8'd1 << $urandom_range(0, 7));
        end
        n = $urandom_range(0, 3);
        repeat (n) begin
            if ($urandom_range(0, 4) < 2) begin
                sz = ($urandom_range(0, 2) == 0) ? 32'($urandom_range(0, 24))
                                                 : whp_pkg::FMT_BODY_BYTES;
                add_fmt(sz, 16'($urandom), $urandom, 16'($urandom));
            end else begin
                add_chunk($urandom, $urandom_range(0, 12));
            end
        end
        add_data($urandom);
        add_noise($urandom_range(0, 3));
        ending = $urandom_range(0, 9);
        if (ending < 2) begin
            mark_last($urandom_range(0, file_q.size() - 1));
        end else if (ending == 2) begin
            idx = $urandom_range(0, file_q.size() - 1);
            while (file_q.size() > idx + 1) void'(file_q.pop_back());
        end
    endtask

    initial begin
        int stall;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            stall = steady ? 0 : $urandom_range(0, 11);
            repeat (stall) begin
                @(negedge aclk);
                m_ready <= 1'b0;
            end
            @(negedge aclk);
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    initial begin
        int idle;
        idle = 0;
        while (idle < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle = 0;
            end else begin
                idle++;
            end
        end
        $display("tb: failure");
        $finish;
    end

    initial begin
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_item     = '0;
        steady     = 1'b0;
        bytes_sent = 0;
        files_sent = 0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // data chunk straight after the header, no first mark after reset
        add_header(whp_pkg::ID_RIFF, '1, whp_pkg::ID_WAVE);
        add_data('1);
        send_file(1'b0);
        hold_off();

        // bad magic in either word; drop the trailing bytes
        add_header(BAD_RIFF, '0, whp_pkg::ID_WAVE);
        add_noise(3);
        send_file(1'b1);
        add_header(whp_pkg::ID_RIFF, '0, BAD_WAVE);
        send_file(1'b1);

        // end before the magic check, and a one-byte file
        add_id(BAD_RIFF);
        add_byte(8'h00);
        mark_last(4);
        send_file(1'b1);
        add_byte(8'hFF);
        mark_last(0);
        send_file(1'b1);
        hold_off();

        // short fmt, odd and empty chunks, last byte on the data header
        steady = 1'b1;
        add_header(whp_pkg::ID_RIFF, '0, whp_pkg::ID_WAVE);
        add_fmt(32'd8, '1, '1, '1);
        add_chunk(ID_LIST, 3);
        add_chunk(ID_JUNK, 0);
        add_data('0);
        mark_last(file_q.size() - 1);
        send_file(1'b1);
        steady = 1'b0;

        // end inside the fmt skip, then inside the fmt body
        add_header(whp_pkg::ID_RIFF, $urandom, whp_pkg::ID_WAVE);
        add_fmt(32'd18, 16'd2, 32'd44100, 16'd16);
        mark_last(file_q.size() - 1);
        send_file(1'b1);
        add_header(whp_pkg::ID_RIFF, $urandom, whp_pkg::ID_WAVE);
        add_fmt(whp_pkg::FMT_BODY_BYTES, 16'd1, 32'd8000, 16'd8);
        mark_last(30);
        send_file(1'b1);

        // restart mid-file; the later fmt chunk wins
        add_header(whp_pkg::ID_RIFF, $urandom, whp_pkg::ID_WAVE);
        add_id(ID_LIST);
        send_file(1'b1);
        add_header(whp_pkg::ID_RIFF, $urandom, whp_pkg::ID_WAVE);
        add_fmt('0, '1, '1, '1);
        add_fmt(whp_pkg::FMT_BODY_BYTES, '0, '0, '0);
        add_data(32'h8000_0001);
        send_file(1'b1);
        hold_off();

        while (bytes_sent < 900 || files_sent < 24) begin
            steady = ($urandom_range(0, 3) == 0);
            build_random_file();
            send_file($urandom_range(0, 19) != 0);
            if ($urandom_range(0, 5) == 0) begin
                hold_off();
            end
        end
        steady = 1'b0;

        hold_off();
        repeat (16) @(posedge aclk);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

`default_nettype wire
